/* src/cpke_pkg.sv */
// ----------------------------------------------------------------------------
// cpke_pkg
// Shared types, codes and helpers for the prefix-compressed record encoder.
// ----------------------------------------------------------------------------
package cpke_pkg;

  // Input item kinds.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_KEY   = 2'd1;
  localparam logic [1:0] REQ_VALUE = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_MARK = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_USE_PREFIX = 2'd0;
  localparam logic [1:0] CFG_RESTART    = 2'd1;

  // One command from the classifier to the emitter. Its results leave in
  // field order: marker, error, header varints, data byte, end marker.
  typedef struct packed {
    logic        mark;
    logic [31:0] mark_off;
    logic        err;
    logic        hdr;
    logic        hdr3;     // three varints (prefix mode) instead of two
    logic [8:0]  h0;
    logic [8:0]  h1;
    logic [31:0] h2;
    logic        data;
    logic [7:0]  dbyte;
    logic        endm;
    logic [31:0] end_off;
  } cmd_t;

  // Number of bytes of the varint32 encoding of v.
  function automatic logic [2:0] varint_len(input logic [31:0] v);
    logic [2:0] n;
    if (v[31:7] == '0)       n = 3'd1;
    else if (v[31:14] == '0) n = 3'd2;
    else if (v[31:21] == '0) n = 3'd3;
    else if (v[31:28] == '0) n = 3'd4;
    else                     n = 3'd5;
    return n;
  endfunction

endpackage

/* src/prefix_compressed_kv_record_encoder_top.sv */
// ----------------------------------------------------------------------------
// prefix_compressed_kv_record_encoder_top
// Key-value record encoder with shared-prefix key compression and restarts.
// ----------------------------------------------------------------------------
// Items arrive on the s_ channel: a record start (lengths), then key bytes,
// then value bytes. Encoded bytes, offset markers and key-too-long errors
// leave on the m_ channel, one per transfer; m_tlast marks the final result
// caused by one input item. Configuration writes use the cfg_ channel, which
// is always ready and should be used only while the block is idle.
// A front stage takes one item per cycle while the queue has room, updates
// the record and prefix state and queues a command; the previous key lives
// in a RAM whose registered read is addressed with the next key index. A
// back stage expands each command into results, one per cycle unless the
// output stalls. Key and value bytes pass at one per cycle unless a side
// stalls. A record start yields up to 9 results and the key byte that
// settles the prefix up to 10, so the four-entry queue fills and s_tready
// drops while a header drains. When m_tready is low the output register
// holds its transfer and the queue fills behind it. Synchronous reset
// empties the queue, restores the register defaults (prefix mode, interval
// 16) and starts a new block with the first marker pending.
// ----------------------------------------------------------------------------
module prefix_compressed_kv_record_encoder_top
  import cpke_pkg::*;
#(
  parameter int MAX_KEY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // key_length[8:0], value_length[40:9], data_byte[48:41]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte[7:0], byte_offset[39:8]
  output logic [1:0]  m_tuser,   // out_kind[1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

  logic          q_full;
  logic          q_push;
  cmd_t          q_cmd;
  logic          q_pop;
  logic          q_valid;
  cmd_t          q_head;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign cfg_ready = 1'b1;

  cpke_front #(.MAX_KEY(MAX_KEY), .AW(AW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_type   (s_tuser),
    .in_klen   (s_tdata[8:0]),
    .in_vlen   (s_tdata[40:9]),
    .in_byte   (s_tdata[48:41]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cpke_ram #(.W(8), .D(MAX_KEY), .AW(AW)) u_prev_key (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cpke_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  cpke_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push) else $error("command pushed into a full queue");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && !q_valid) else $error("output or queue busy after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_MARK || m_tuser == KIND_ERR))
    else $error("illegal result kind");

  a_fields_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_DATA |-> m_tdata[7:0] == '0)
    else $error("nonzero byte on a marker or error");

endmodule

/* src/cpke_ram.sv */
// ----------------------------------------------------------------------------
// cpke_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpke_ram #(
  parameter int W = 8,
  parameter int D = 256,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/cpke_fifo.sv */
// ----------------------------------------------------------------------------
// cpke_fifo
// Short command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module cpke_fifo
  import cpke_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int Depth = 4;
  localparam int PW = $clog2(Depth);

  cmd_t          slots [Depth];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full       = (count == (PW+1)'(Depth));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* src/cpke_front.sv */
// ----------------------------------------------------------------------------
// cpke_front
// Accepts items, tracks record and prefix state, and queues one command per
// item that gives results.
// ----------------------------------------------------------------------------
module cpke_front
  import cpke_pkg::*;
#(
  parameter int MAX_KEY = 256,
  parameter int AW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_type,
  input  logic [8:0]    in_klen,
  input  logic [31:0]   in_vlen,
  input  logic [7:0]    in_byte,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam logic [12:0] MaxKey = 13'(MAX_KEY);

  logic        use_prefix;
  logic [15:0] restart_interval;
  logic [8:0]  prev_len, prev_len_next;
  logic [15:0] since_restart, since_restart_next;
  logic [31:0] bytes_out, bytes_out_next;
  logic [8:0]  key_index, key_index_next;
  logic        resolved, resolved_next;
  logic [8:0]  key_len, key_len_next;
  logic [31:0] value_rem, value_rem_next;
  logic        started, started_next;

  logic        accept;
  logic        restart;
  logic [8:0]  min_len;
  logic [8:0]  key_index_inc;
  logic [5:0]  hdr_len;
  cmd_t        cmd;

  assign in_ready  = !q_full;
  assign accept    = in_valid && !q_full;
  assign mem_waddr = AW'(key_index);
  assign mem_wdata = in_byte;
  assign mem_raddr = AW'(key_index_next);
  assign key_index_inc = key_index + 9'd1;

  always_comb begin
    prev_len_next      = prev_len;
    since_restart_next = since_restart;
    key_index_next     = key_index;
    resolved_next      = resolved;
    key_len_next       = key_len;
    value_rem_next     = value_rem;
    started_next       = started;
    restart            = 1'b0;
    min_len            = '0;
    mem_we             = 1'b0;
    cmd                = '0;

    if (accept) begin
      case (in_type)
        REQ_START: begin
          if (started && use_prefix) prev_len_next = key_index;
          started_next = 1'b0;
          if (13'(in_klen) > MaxKey) begin
            cmd.err = 1'b1;
          end else begin
            key_len_next   = in_klen;
            value_rem_next = in_vlen;
            key_index_next = '0;
            resolved_next  = 1'b0;
            started_next   = 1'b1;
            if (use_prefix) begin
              restart = (since_restart == '0) || (since_restart >= restart_interval);
              if (restart) begin
                cmd.mark           = 1'b1;
                cmd.mark_off       = bytes_out;
                since_restart_next = 16'd1;
              end else begin
                since_restart_next = since_restart + 16'd1;
              end
              min_len = (prev_len_next < in_klen) ? prev_len_next : in_klen;
              if (restart || min_len == '0) begin
                cmd.hdr       = 1'b1;
                cmd.hdr3      = 1'b1;
                cmd.h0        = '0;
                cmd.h1        = in_klen;
                cmd.h2        = in_vlen;
                resolved_next = 1'b1;
              end
              if (in_klen == '0) prev_len_next = '0;
            end else begin
              cmd.hdr = 1'b1;
              cmd.h0  = in_klen;
              cmd.h2  = in_vlen;
            end
            if (in_klen == '0 && in_vlen == '0) begin
              started_next = 1'b0;
              cmd.endm     = !use_prefix;
            end
          end
        end
        REQ_KEY: begin
          if (started && key_index < key_len) begin
            if (use_prefix) begin
              mem_we = 1'b1;
              if (!resolved) begin
                min_len = (prev_len < key_len) ? prev_len : key_len;
                if (key_index >= min_len || in_byte != mem_rdata) begin
                  cmd.hdr       = 1'b1;
                  cmd.hdr3      = 1'b1;
                  cmd.h0        = key_index;
                  cmd.h1        = key_len - key_index;
                  cmd.h2        = value_rem;
                  cmd.data      = 1'b1;
                  cmd.dbyte     = in_byte;
                  resolved_next = 1'b1;
                end else if (key_index_inc == min_len) begin
                  cmd.hdr       = 1'b1;
                  cmd.hdr3      = 1'b1;
                  cmd.h0        = key_index_inc;
                  cmd.h1        = key_len - key_index_inc;
                  cmd.h2        = value_rem;
                  resolved_next = 1'b1;
                end
              end else begin
                cmd.data  = 1'b1;
                cmd.dbyte = in_byte;
              end
              if (key_index_inc == key_len) prev_len_next = key_len;
            end else begin
              cmd.data  = 1'b1;
              cmd.dbyte = in_byte;
            end
            key_index_next = key_index_inc;
            if (key_index_inc == key_len && value_rem == '0) begin
              started_next = 1'b0;
              cmd.endm     = !use_prefix;
            end
          end
        end
        REQ_VALUE: begin
          if (started && key_index == key_len && value_rem != '0) begin
            cmd.data       = 1'b1;
            cmd.dbyte      = in_byte;
            value_rem_next = value_rem - 32'd1;
            if (value_rem == 32'd1) begin
              started_next = 1'b0;
              cmd.endm     = !use_prefix;
            end
          end
        end
        default: begin
        end
      endcase
    end

    hdr_len = '0;
    if (cmd.hdr) begin
      hdr_len = 6'(varint_len(32'(cmd.h0))) + 6'(varint_len(cmd.h2))
              + (cmd.hdr3 ? 6'(varint_len(32'(cmd.h1))) : 6'd0);
    end
    bytes_out_next = bytes_out + 32'(hdr_len) + 32'(cmd.data);
    cmd.end_off    = cmd.endm ? bytes_out_next : '0;
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.mark || cmd.err || cmd.hdr || cmd.data || cmd.endm);

  always_ff @(posedge clk) begin
    if (rst) begin
      use_prefix       <= 1'b1;
      restart_interval <= 16'd16;
      prev_len         <= '0;
      since_restart    <= '0;
      bytes_out        <= '0;
      key_index        <= '0;
      resolved         <= 1'b0;
      key_len          <= '0;
      value_rem        <= '0;
      started          <= 1'b0;
    end else if (cfg_valid && cfg_index == CFG_USE_PREFIX) begin
      // Switching mode opens a new block.
      use_prefix    <= cfg_data[0];
      prev_len      <= '0;
      since_restart <= '0;
      bytes_out     <= '0;
      key_index     <= '0;
      resolved      <= 1'b0;
      key_len       <= '0;
      value_rem     <= '0;
      started       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == CFG_RESTART) restart_interval <= cfg_data;
      prev_len      <= prev_len_next;
      since_restart <= since_restart_next;
      bytes_out     <= bytes_out_next;
      key_index     <= key_index_next;
      resolved      <= resolved_next;
      key_len       <= key_len_next;
      value_rem     <= value_rem_next;
      started       <= started_next;
    end
  end

endmodule

/* src/cpke_back.sv */
// ----------------------------------------------------------------------------
// cpke_back
// Expands queued commands into result items, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module cpke_back
  import cpke_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam logic [2:0] PH_MARK = 3'd0;
  localparam logic [2:0] PH_ERR  = 3'd1;
  localparam logic [2:0] PH_V0   = 3'd2;
  localparam logic [2:0] PH_V1   = 3'd3;
  localparam logic [2:0] PH_V2   = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_END  = 3'd6;

  logic [2:0]  phase;
  logic [2:0]  grp;
  logic [6:0]  en;
  logic [2:0]  cur;
  logic        later;
  logic [31:0] src;
  logic [31:0] v;
  logic        more;
  logic        done;
  logic        last;
  logic        fire;
  logic [1:0]  r_kind;
  logic [7:0]  r_byte;
  logic [31:0] r_off;

  always_comb begin
    en = {q_cmd.endm, q_cmd.data, q_cmd.hdr, q_cmd.hdr & q_cmd.hdr3,
          q_cmd.hdr, q_cmd.err, q_cmd.mark};
    cur = PH_END;
    for (int i = 6; i >= 0; i--) begin
      if (en[i] && 3'(i) >= phase) cur = 3'(i);
    end
    later = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (en[i] && 3'(i) > cur) later = 1'b1;
    end

    case (cur)
      PH_V0:   src = 32'(q_cmd.h0);
      PH_V1:   src = 32'(q_cmd.h1);
      default: src = q_cmd.h2;
    endcase
    case (grp)
      3'd0:    v = src;
      3'd1:    v = src >> 7;
      3'd2:    v = src >> 14;
      3'd3:    v = src >> 21;
      default: v = src >> 28;
    endcase
    more = (v[31:7] != '0);

    done   = 1'b1;
    r_kind = KIND_DATA;
    r_byte = '0;
    r_off  = '0;
    case (cur)
      PH_MARK: begin
        r_kind = KIND_MARK;
        r_off  = q_cmd.mark_off;
      end
      PH_ERR:  r_kind = KIND_ERR;
      PH_V0, PH_V1, PH_V2: begin
        r_byte = more ? {1'b1, v[6:0]} : v[7:0];
        done   = !more;
      end
      PH_DATA: r_byte = q_cmd.dbyte;
      PH_END: begin
        r_kind = KIND_MARK;
        r_off  = q_cmd.end_off;
      end
      default: r_kind = KIND_DATA;
    endcase
    last = done && !later;
  end

  assign fire  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = fire && last;

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {r_off, r_byte};
      m_tuser <= r_kind;
      m_tlast <= last;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= PH_MARK;
      grp      <= '0;
    end else begin
      if (fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (fire) begin
        if (last) begin
          phase <= PH_MARK;
          grp   <= '0;
        end else if (done) begin
          phase <= cur + 3'd1;
          grp   <= '0;
        end else begin
          grp <= grp + 3'd1;
        end
      end
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the prefix-compressed key-value record encoder.
// ----------------------------------------------------------------------------
// A record-level predictor tracks the previous key, the restart count and
// the running output byte count. Each item accepted on the input stream is
// run through the predictor, and the expected results queue up in order.
// A checker compares each output transfer field by field with the oldest
// entry. Directed tests cover both modes, the length extremes, oversized
// keys, stray and abandoned items and restart intervals 0, 1, 3 and 65535.
// A long output stall and a random phase follow; both sides pause at random.
// ----------------------------------------------------------------------------
module tb;
  import cpke_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_MAX    = 256;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 20;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] offset;
    logic        last;
  } enc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = REQ_START;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_USE_PREFIX;
  logic [15:0] cfg_data = '0;

  prefix_compressed_kv_record_encoder_top #(.MAX_KEY(KEY_MAX)) dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic [7:0]  pk_key[KEY_MAX];
  int          pk_len;
  int          since_restart;
  logic [31:0] out_count;
  int          key_pos;
  bit          prefix_known;
  int          rec_klen;
  logic [31:0] val_left;
  bit          rec_open;
  bit          prefix_mode;
  logic [15:0] interval;

  enc_result_t expected_q[$];

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_records = 0;
  int hold_cycles = 0;
  int rx_stall = 0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;
  int idle_count = 0;

  // Key generator: new keys share a random prefix with the last one.
  logic [7:0] gen_prev[KEY_MAX];
  int         gen_prev_len = 0;
  logic [7:0] gen_key[KEY_MAX];

  function automatic void put(logic [1:0] kind, logic [7:0] data, logic [31:0] off);
    enc_result_t r;
    r.kind = kind;
    r.data = data;
    r.offset = off;
    r.last = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void put_data(logic [7:0] b);
    put(KIND_DATA, b, '0);
    out_count = out_count + 1;
  endfunction

  function automatic void put_varint(logic [31:0] v);
    while (v >= 32'h80) begin
      put_data({1'b1, v[6:0]});
      v = v >> 7;
    end
    put_data(v[7:0]);
  endfunction

  function automatic void put_header(int shared);
    put_varint(shared);
    put_varint(rec_klen - shared);
    put_varint(val_left);
    prefix_known = 1'b1;
  endfunction

  function automatic void close_if_done();
    if (rec_open && key_pos == rec_klen && val_left == 0) begin
      rec_open = 1'b0;
      if (!prefix_mode) put(KIND_MARK, '0, out_count);
    end
  endfunction

  function automatic void start_block();
    pk_len = 0;
    since_restart = 0;
    out_count = '0;
    key_pos = 0;
    prefix_known = 1'b0;
    rec_klen = 0;
    val_left = '0;
    rec_open = 1'b0;
  endfunction

  function automatic void encode_item(logic [1:0] req, logic [8:0] klen, logic [31:0] vlen,
                                      logic [7:0] b);
    int  n0;
    int  minl;
    bit  force_restart;
    n0 = expected_q.size();
    case (req)
      REQ_START: begin
        if (rec_open && prefix_mode) pk_len = key_pos;
        rec_open = 1'b0;
        if (klen > KEY_MAX) begin
          put(KIND_ERR, '0, '0);
        end else begin
          rec_klen = klen;
          val_left = vlen;
          key_pos = 0;
          prefix_known = 1'b0;
          rec_open = 1'b1;
          if (prefix_mode) begin
            force_restart = 1'b0;
            if (since_restart == 0 || since_restart >= interval) begin
              put(KIND_MARK, '0, out_count);
              since_restart = 0;
              force_restart = 1'b1;
            end
            since_restart++;
            minl = (pk_len < rec_klen) ? pk_len : rec_klen;
            if (force_restart || minl == 0) put_header(0);
            if (rec_klen == 0) pk_len = 0;
          end else begin
            put_varint(32'(klen));
            put_varint(vlen);
          end
          close_if_done();
        end
      end
      REQ_KEY: begin
        if (rec_open && key_pos < rec_klen) begin
          if (prefix_mode) begin
            if (!prefix_known) begin
              minl = (pk_len < rec_klen) ? pk_len : rec_klen;
              if (key_pos >= minl || b != pk_key[key_pos]) begin
                put_header(key_pos);
                put_data(b);
              end else if (key_pos + 1 == minl) begin
                put_header(key_pos + 1);
              end
            end else begin
              put_data(b);
            end
            pk_key[key_pos] = b;
          end else begin
            put_data(b);
          end
          key_pos++;
          if (prefix_mode && key_pos == rec_klen) pk_len = rec_klen;
          close_if_done();
        end
      end
      REQ_VALUE: begin
        if (rec_open && key_pos == rec_klen && val_left > 0) begin
          put_data(b);
          val_left = val_left - 1;
          close_if_done();
        end
      end
      default: ;
    endcase
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // Offers one item after a random gap and predicts it once it is accepted.
  // The valid stays high across back-to-back items.
  task automatic send_item(logic [1:0] req, logic [8:0] klen, logic [31:0] vlen,
                           logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {7'd0, b, vlen, klen};
    do @(posedge clk); while (!s_tready);
    encode_item(req, klen, vlen, b);
    n_items++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_USE_PREFIX) begin
      prefix_mode = val[0];
      start_block();
    end else if (idx == CFG_RESTART) begin
      interval = val;
    end
  endtask

  // Builds a key of klen bytes that usually shares a prefix with the last key.
  task automatic make_key(int klen);
    int share;
    share = (gen_prev_len < klen) ? gen_prev_len : klen;
    share = $urandom_range(0, share);
    for (int i = 0; i < klen; i++)
      gen_key[i] = (i < share) ? gen_prev[i] : 8'($urandom);
    for (int i = 0; i < klen; i++) gen_prev[i] = gen_key[i];
    gen_prev_len = klen;
  endtask

  // Sends a start and then nkey key bytes and nval value bytes; sending fewer
  // than the lengths leaves the record open for the next start to abandon.
  task automatic send_record(int klen, logic [31:0] vlen, int nkey, int nval);
    make_key(klen);
    send_item(REQ_START, 9'(klen), vlen, 8'($urandom));
    for (int i = 0; i < nkey; i++) send_item(REQ_KEY, '0, '0, gen_key[i]);
    for (int i = 0; i < nval; i++) send_item(REQ_VALUE, '0, '0, 8'($urandom));
    n_records++;
  endtask

  task automatic send_full(int klen, int vlen);
    send_record(klen, 32'(vlen), klen, vlen);
  endtask

  task automatic send_random_record();
    int r;
    int klen;
    int vlen;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_item(2'($urandom_range(1, 3)), 9'($urandom), $urandom, 8'($urandom));
    end else if (r < 10) begin
      send_item(REQ_START, 9'($urandom_range(KEY_MAX + 1, 511)), $urandom, 8'($urandom));
    end else if (r < 12) begin
      // A huge value length is abandoned after a few bytes.
      klen = $urandom_range(0, 4);
      send_record(klen, $urandom | 32'h8000_0000, klen, $urandom_range(0, 3));
    end else if (r < 20) begin
      klen = $urandom_range(1, 6);
      send_record(klen, $urandom_range(0, 3), $urandom_range(0, klen - 1), 0);
    end else begin
      klen = (gen_prev_len < 6 ? gen_prev_len : 6) + $urandom_range(0, 3) - 1;
      if (klen < 0) klen = 0;
      vlen = $urandom_range(0, 3);
      send_full(klen, vlen);
    end
  endtask

  task automatic test_prefix_directed();
    send_full(0, 0);
    send_full(3, 1);
    send_full(3, 0);
    send_full(5, 0);
    send_item(REQ_START, 9'd511, '0, '0);
    send_item(REQ_START, 9'(KEY_MAX + 1), '0, '0);
    send_item(REQ_KEY, '0, '0, 8'hFF);
    send_item(2'd3, 9'h1FF, 32'hFFFF_FFFF, 8'hFF);
    send_record(2, 32'hFFFF_FFFF, 1, 0);
    send_item(REQ_VALUE, '0, '0, 8'h00);
    send_item(REQ_KEY, '0, '0, 8'h5A);
    send_item(REQ_VALUE, '0, '0, 8'hA5);
    send_item(REQ_VALUE, '0, '0, 8'h3C);
    send_item(REQ_KEY, '0, '0, 8'h11);
    send_full(2, 0);
  endtask

  task automatic test_plain_mode();
    write_reg(CFG_USE_PREFIX, 16'd0);
    send_full(0, 0);
    send_full(2, 3);
    send_record(3, 200, 1, 0);
    send_full(1, 0);
    send_item(REQ_START, 9'd300, 32'd5, '0);
    repeat (3) send_random_record();
    write_reg(CFG_USE_PREFIX, 16'd1);
  endtask

  task automatic test_restart_intervals();
    logic [15:0] settings[4] = '{16'd1, 16'd65535, 16'd0, 16'd3};
    foreach (settings[i]) begin
      write_reg(CFG_RESTART, settings[i]);
      repeat (2) send_random_record();
    end
    write_reg(CFG_USE_PREFIX, 16'd1);
    write_reg(CFG_RESTART, 16'd16);
  endtask

  // Keys of the largest length, left open after a few key bytes.
  task automatic test_long_key();
    send_record(KEY_MAX, 32'd1, 3, 0);
    send_record(KEY_MAX, 32'hFFFF_FFFF, 3, 0);
  endtask

  task automatic test_output_stall();
    wait_idle();
    hold_cycles = 300;
    repeat (4) send_random_record();
  endtask

  task automatic test_random();
    int start;
    start = n_items;
    while (n_items - start < 30) begin
      if ($urandom_range(0, 29) == 0) begin
        rx_calm = $urandom_range(0, 1);
        tx_calm = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 39) == 0) begin
        write_reg(CFG_RESTART, 16'($urandom_range(1, 5)));
        if ($urandom_range(0, 2) == 0) write_reg(CFG_USE_PREFIX, 16'($urandom_range(0, 1)));
      end
      send_random_record();
    end
    rx_calm = 1'b0;
    tx_calm = 1'b0;
  endtask

  // Output checker and receiver stalls.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      enc_result_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer kind=%0d byte=%h off=%h last=%b",
                 $time, m_tuser, m_tdata[7:0], m_tdata[39:8], m_tlast);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_tuser !== e.kind || m_tdata[7:0] !== e.data || m_tdata[39:8] !== e.offset ||
            m_tlast !== e.last) begin
          $display("%0t: mismatch expected kind=%0d byte=%h off=%h last=%b",
                   $time, e.kind, e.data, e.offset, e.last);
          $display("%0t:          actual   kind=%0d byte=%h off=%h last=%b",
                   $time, m_tuser, m_tdata[7:0], m_tdata[39:8], m_tlast);
          errors++;
        end
      end
      rx_stall = rx_calm ? 0 : $urandom_range(0, 7);
    end
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else if (idle_count >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end else
      idle_count <= idle_count + 1;
  end

  initial begin
    prefix_mode = 1'b1;
    interval = 16'd16;
    start_block();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_prefix_directed();
    test_plain_mode();
    test_restart_intervals();
    test_long_key();
    test_output_stall();
    test_random();
    wait_idle();
    $display("Sent %0d items in %0d records, checked %0d results.", n_items, n_records,
             n_results);
    $display("Both modes, restart intervals 0 to 65535, oversized and abandoned records.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
src/cpke_pkg.sv
src/cpke_ram.sv
src/cpke_fifo.sv
src/cpke_front.sv
src/cpke_back.sv
src/prefix_compressed_kv_record_encoder_top.sv
test/tb.sv
